>>> design/utf8_to_utf16_transcoder_macros.svh
// Assertion macros for the UTF-8 to UTF-16 transcoder checks.
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

// Check held off while reset is high.
`define U8U16_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("u8u16 check failed");

// Check that also runs through reset.
`define U8U16_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("u8u16 check failed");

`endif

>>> design/u8u16_pkg.sv
// Shared types, constants and the filename character table for the transcoder.
`default_nettype none
package u8u16_pkg;

   localparam int unsigned MaxResults = 3;

   localparam logic [1:0] CSR_FILENAME_MODE = 2'd0;
   localparam logic [1:0] CSR_COUNT_ONLY    = 2'd1;
   localparam logic [1:0] CSR_OUT_CAPACITY  = 2'd2;

   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
   localparam logic [15:0] SURROGATE_HIGH = 16'hD800;
   localparam logic [15:0] SURROGATE_LOW  = 16'hDC00;
   localparam logic [15:0] PRIVATE_BASE   = 16'hF000;
   localparam logic [20:0] SUPPLEMENTARY  = 21'h10000;

   typedef struct packed {
      logic        filename_mode;
      logic        count_only;
      logic [15:0] out_capacity;
   } cfg_type;

   typedef struct packed {
      logic [20:0] partial_code_point;
      logic [1:0]  bytes_pending;
      logic        error_seen;
      logic [15:0] units_so_far;
   } state_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        is_status;
      logic        failed;
      logic [15:0] unit_total;
      logic        last_of_run;
   } rsp_type;

   typedef rsp_type [MaxResults-1:0] burst_type;

   function automatic logic [15:0] remap_name_char(input logic [6:0] c);
      logic [15:0] r;
      r = {9'd0, c};
      if (c == 7'h00) begin
         r = 16'h0000;
      end else if (c < 7'h20 || c == 7'h22 || c == 7'h2A || c == 7'h3A ||
                   c == 7'h3C || c == 7'h3E || c == 7'h3F || c == 7'h7C) begin
         r = PRIVATE_BASE | {9'd0, c};
      end else if (c == 7'h2F) begin
         r = 16'h005C;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/u8u16_step.sv
// Per-byte decode: next string state and the burst of results for one byte.
`default_nettype none
module u8u16_step
   import u8u16_pkg::*;
(
   input  cfg_type     cfg,
   input  state_type   state,
   input  logic [7:0]  in_byte,
   input  logic        end_of_string,
   output state_type   state_next,
   output burst_type   burst,
   output logic [1:0]  burst_count
);

   always_comb begin
      logic        complete;
      logic [20:0] cp_raw;
      logic [20:0] cp;
      logic [20:0] cp_off;
      logic [20:0] merged;
      logic [1:0]  pend;
      logic        two;
      logic [16:0] sum;
      logic [1:0]  k;

      state_next  = state;
      burst       = '0;
      complete    = 1'b0;
      cp_raw      = '0;
      merged      = '0;
      pend        = '0;
      k           = '0;

      if (!state.error_seen) begin
         if (state.bytes_pending == 2'd0) begin
            if (in_byte[7] == 1'b0) begin
               complete = 1'b1;
               cp_raw   = {14'd0, in_byte[6:0]};
            end else if (in_byte[7:5] == 3'b110) begin
               state_next.partial_code_point = {10'd0, in_byte[4:0], 6'd0};
               state_next.bytes_pending      = 2'd1;
            end else if (in_byte[7:4] == 4'b1110) begin
               state_next.partial_code_point = {5'd0, in_byte[3:0], 12'd0};
               state_next.bytes_pending      = 2'd2;
            end else if (in_byte[7:3] == 5'b11110) begin
               state_next.partial_code_point = {in_byte[2:0], 18'd0};
               state_next.bytes_pending      = 2'd3;
            end else begin
               state_next.error_seen = 1'b1;
            end
         end else begin
            pend = state.bytes_pending - 2'd1;
            case (pend)
               2'd0:    merged = state.partial_code_point | {15'd0, in_byte[5:0]};
               2'd1:    merged = state.partial_code_point | {9'd0, in_byte[5:0], 6'd0};
               2'd2:    merged = state.partial_code_point | {3'd0, in_byte[5:0], 12'd0};
               default: merged = state.partial_code_point;
            endcase
            state_next.bytes_pending      = pend;
            state_next.partial_code_point = merged;
            if (pend == 2'd0) begin
               complete                      = 1'b1;
               cp_raw                        = merged;
               state_next.partial_code_point = '0;
            end
         end
      end

      if (cfg.filename_mode && cp_raw < 21'h80) begin
         cp = {5'd0, remap_name_char(cp_raw[6:0])};
      end else begin
         cp = cp_raw;
      end
      two    = cp > 21'h00FFFF;
      sum    = {1'b0, state.units_so_far} + (two ? 17'd2 : 17'd1);
      cp_off = cp - SUPPLEMENTARY;

      if (complete) begin
         if (cfg.count_only) begin
            state_next.units_so_far = sum[16] ? 16'hFFFF : sum[15:0];
         end else if (sum > {1'b0, cfg.out_capacity}) begin
            state_next.error_seen = 1'b1;
         end else begin
            if (two) begin
               burst[0].code_unit = SURROGATE_HIGH + {5'd0, cp_off[20:10]};
               burst[1].code_unit = SURROGATE_LOW + {6'd0, cp_off[9:0]};
               k = 2'd2;
            end else begin
               burst[0].code_unit = cp[15:0];
               k = 2'd1;
            end
            state_next.units_so_far = sum[15:0];
         end
      end

      if (end_of_string) begin
         if (state_next.bytes_pending != 2'd0) begin
            state_next.error_seen = 1'b1;
         end
         burst[k].is_status  = 1'b1;
         burst[k].failed     = state_next.error_seen;
         burst[k].unit_total = state_next.units_so_far;
         k          = k + 2'd1;
         state_next = '0;
      end

      if (k != 2'd0) begin
         burst[k - 2'd1].last_of_run = 1'b1;
      end
      burst_count = k;
   end

endmodule
`default_nettype wire

>>> design/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder top level: string state, config and result buffer.
//
// Request channel (req_*): one UTF-8 byte per request, req_end_of_string on the
// last byte of a string. Response channel (rsp_*): UTF-16 code units, and one
// status response per string carrying the error flag and the unit count.
// rsp_last_of_run marks the last response caused by a request.
// A request is decoded in the cycle it is accepted; its responses (zero to
// three) sit in a three-entry buffer and the first shows on rsp_* the next
// cycle. Throughput: one byte per cycle while each byte gives at most one
// response and rsp_ready is high; a byte giving more responses holds the
// response port until they drain, and the next request is taken in the cycle
// the buffer's last entry leaves. Config is written through csr_* by the user
// only while no string is in flight; the block itself does not enforce it.
// Writes to an index past out_capacity are dropped.
// Reset (synchronous) clears the string state, empties the buffer and
// restores the config defaults. A stalled receiver stops intake while any
// response is waiting in the buffer.
`default_nettype none
module utf8_to_utf16_transcoder
   import u8u16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_is_status,
   output logic        rsp_failed,
   output logic [15:0] rsp_unit_total,
   output logic        rsp_last_of_run,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   burst_type  slots_ff;
   burst_type  burst;
   logic [1:0] count_ff;
   logic [1:0] burst_count;
   logic       accept;
   logic       pop;

   u8u16_step step (
      .cfg           (cfg_ff),
      .state         (state_ff),
      .in_byte       (req_in_byte),
      .end_of_string (req_end_of_string),
      .state_next    (state_in),
      .burst         (burst),
      .burst_count   (burst_count)
   );

   assign rsp_valid = count_ff != 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_ready);
   assign accept    = req_valid && req_ready;

   assign rsp_code_unit   = slots_ff[0].code_unit;
   assign rsp_is_status   = slots_ff[0].is_status;
   assign rsp_failed      = slots_ff[0].failed;
   assign rsp_unit_total  = slots_ff[0].unit_total;
   assign rsp_last_of_run = slots_ff[0].last_of_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filename_mode <= 1'b0;
         cfg_ff.count_only    <= 1'b0;
         cfg_ff.out_capacity  <= CAPACITY_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FILENAME_MODE: cfg_ff.filename_mode <= csr_write_data[0];
            CSR_COUNT_ONLY:    cfg_ff.count_only    <= csr_write_data[0];
            CSR_OUT_CAPACITY:  cfg_ff.out_capacity  <= csr_write_data;
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         count_ff <= 2'd0;
      end else if (accept) begin
         state_ff <= state_in;
         count_ff <= burst_count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slots_ff <= burst;
      end else if (pop) begin
         slots_ff[0] <= slots_ff[1];
         slots_ff[1] <= slots_ff[2];
      end
   end

endmodule
`default_nettype wire

>>> design/u8u16_checker.sv
// Port-level checks on the transcoder response channel, bound to the top level.
`default_nettype none
`include "utf8_to_utf16_transcoder_macros.svh"
module u8u16_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_code_unit,
   input logic        rsp_is_status,
   input logic        rsp_failed,
   input logic [15:0] rsp_unit_total,
   input logic        rsp_last_of_run
);

   `U8U16_ASSERT(rsp_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `U8U16_ASSERT(status_ends_run, clock, reset, rsp_valid && rsp_is_status |-> rsp_last_of_run)
   `U8U16_ASSERT(status_no_unit, clock, reset, rsp_valid && rsp_is_status |-> rsp_code_unit == 16'd0)
   `U8U16_ASSERT(unit_no_status, clock, reset, rsp_valid && !rsp_is_status |-> !rsp_failed && rsp_unit_total == 16'd0)
   `U8U16_ASSERT_ALWAYS(reset_empties, clock, reset |=> !rsp_valid)

endmodule

bind utf8_to_utf16_transcoder u8u16_checker checker_inst (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_code_unit   (rsp_code_unit),
   .rsp_is_status   (rsp_is_status),
   .rsp_failed      (rsp_failed),
   .rsp_unit_total  (rsp_unit_total),
   .rsp_last_of_run (rsp_last_of_run)
);
`default_nettype wire
